// ===== rtl/dlmv_pkg.sv =====
// Shared types and constants of the dense layer matrix-vector block.
// Holds the operation codes, the command and configuration structs and the queue sizes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dlmv_pkg;

	localparam int ROW_W      = 6;
	localparam int COL_W      = 8;
	localparam int VAL_W      = 16;
	localparam int RES_W      = 32;
	localparam int IN_LEN_W   = 9;
	localparam int OUT_LEN_W  = 7;
	localparam int CFG_DATA_W = 9;
	localparam int CFG_IDX_W  = 2;
	localparam int FRAC_BITS  = 8;

	localparam logic [CFG_IDX_W-1:0] REG_INPUT_LENGTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LENGTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BIAS_ENABLE   = 2'd2;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		OP_LOAD_INPUT  = 2'd0,
		OP_LOAD_WEIGHT = 2'd1,
		OP_LOAD_BIAS   = 2'd2,
		OP_START       = 2'd3
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} cmd_t;

	typedef struct packed {
		logic [IN_LEN_W-1:0]  input_length;
		logic [OUT_LEN_W-1:0] output_length;
		logic                 bias_enable;
	} cfg_t;

endpackage

`default_nettype wire

// ===== rtl/dlmv_if.sv =====
// Channel interfaces of the dense layer matrix-vector block.
// Depends on dlmv_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface dlmv_load_if import dlmv_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [1:0]              operation;
	logic [ROW_W-1:0]        row_index;
	logic [COL_W-1:0]        column_index;
	logic signed [VAL_W-1:0] load_value;

	modport source (output valid, operation, row_index, column_index, load_value,
		input ready);
	modport sink (input valid, operation, row_index, column_index, load_value,
		output ready);
endinterface

interface dlmv_result_if import dlmv_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [ROW_W-1:0]        result_row;
	logic signed [RES_W-1:0] result_value;
	logic                    last_row;

	modport source (output valid, result_row, result_value, last_row, input ready);
	modport sink (input valid, result_row, result_value, last_row, output ready);
endinterface

`default_nettype wire

// ===== rtl/dense_layer_matrix_vector.sv =====
// Top level of the dense layer matrix-vector block: configuration registers,
// front end with its command queue, and back end. Depends on dlmv_pkg, dlmv_if,
// dlmv_front and dlmv_back.
//
// Load items (input element, weight, bias) are taken one per cycle while the
// four-item command queue has room, and are written into the stores as they
// leave it; loads to addresses beyond the stores are dropped. A start item
// computes, for each output row in turn, bias (when enabled) plus the sum of
// input times weight in Q8.8, kept in an ACC_WIDTH-bit accumulator and delivered
// as a saturated Q16.16 result with the final row marked. For each row, S_BIAS
// fetches the bias, then in S_MAC a single multiply-accumulate unit reads one
// weight and one input element per cycle through one read port each and ends
// the row, S_DRAIN empties the multiplier pipeline and S_EMIT, which waits while
// an earlier result has not been taken, hands the row to the output register.
// Items queued behind a start wait until its last row has been handed over.
// Configuration is to be written by the user only while the block is idle; the
// block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module dense_layer_matrix_vector import dlmv_pkg::*; #(
	parameter int MAX_INPUTS  = 256,
	parameter int MAX_OUTPUTS = 64,
	parameter int DATA_WIDTH  = 16,
	parameter int ACC_WIDTH   = 40
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  reg_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	dlmv_load_if.sink             load_ch,
	dlmv_result_if.source         result_ch
);

	cfg_t                  cfg_q;
	logic                  cmd_valid;
	cmd_t                  cmd;
	logic [DATA_WIDTH-1:0] cmd_value;
	logic                  cmd_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.input_length  <= IN_LEN_W'(1);
			cfg_q.output_length <= OUT_LEN_W'(1);
			cfg_q.bias_enable   <= 1'b1;
		end else if (wr_en) begin
			case (reg_index)
				REG_INPUT_LENGTH:  cfg_q.input_length  <= wr_data[IN_LEN_W-1:0];
				REG_OUTPUT_LENGTH: cfg_q.output_length <= wr_data[OUT_LEN_W-1:0];
				REG_BIAS_ENABLE:   cfg_q.bias_enable   <= wr_data[0];
				default: begin
				end
			endcase
		end
	end

	dlmv_front #(
		.MAX_INPUTS  (MAX_INPUTS),
		.MAX_OUTPUTS (MAX_OUTPUTS),
		.DATA_WIDTH  (DATA_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (load_ch),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_value (cmd_value),
		.cmd_pop   (cmd_pop)
	);

	dlmv_back #(
		.MAX_INPUTS  (MAX_INPUTS),
		.MAX_OUTPUTS (MAX_OUTPUTS),
		.DATA_WIDTH  (DATA_WIDTH),
		.ACC_WIDTH   (ACC_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_value (cmd_value),
		.cmd_pop   (cmd_pop),
		.results   (result_ch)
	);

endmodule

`default_nettype wire

// ===== rtl/dlmv_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module dlmv_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/dlmv_front.sv =====
// Front end: accepts items, drops loads with out-of-range addresses, fits values
// to the data width and queues commands for the back end. Depends on dlmv_pkg, dlmv_if.
`timescale 1ns / 1ps
`default_nettype none

module dlmv_front import dlmv_pkg::*; #(
	parameter int MAX_INPUTS  = 256,
	parameter int MAX_OUTPUTS = 64,
	parameter int DATA_WIDTH  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	dlmv_load_if.sink             items,
	output logic                  cmd_valid,
	output cmd_t                  cmd,
	output logic [DATA_WIDTH-1:0] cmd_value,
	input  logic                  cmd_pop
);

	cmd_t                  qcmd_q [QUEUE_DEPTH];
	logic [DATA_WIDTH-1:0] qval_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]     wr_ptr_q;
	logic [QPTR_W-1:0]     rd_ptr_q;
	logic [QCNT_W-1:0]     cnt_q;
	op_t                   op;
	logic                  row_ok;
	logic                  col_ok;
	logic                  keep;
	logic                  push;
	cmd_t                  new_cmd;

	assign op     = op_t'(items.operation);
	assign row_ok = 32'(items.row_index) < 32'(MAX_OUTPUTS);
	assign col_ok = 32'(items.column_index) < 32'(MAX_INPUTS);

	always_comb begin
		case (op)
			OP_LOAD_INPUT:  keep = col_ok;
			OP_LOAD_WEIGHT: keep = row_ok && col_ok;
			OP_LOAD_BIAS:   keep = row_ok;
			OP_START:       keep = 1'b1;
			default:        keep = 1'b0;
		endcase
	end

	assign items.ready = cnt_q != QCNT_W'(QUEUE_DEPTH);
	assign push        = items.valid && items.ready && keep;
	assign new_cmd     = '{op: op, row: items.row_index, col: items.column_index};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= QPTR_W'(wr_ptr_q + QPTR_W'(1));
			end
			if (cmd_pop) begin
				rd_ptr_q <= QPTR_W'(rd_ptr_q + QPTR_W'(1));
			end
			cnt_q <= QCNT_W'(cnt_q + QCNT_W'(push) - QCNT_W'(cmd_pop));
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			qcmd_q[wr_ptr_q] <= new_cmd;
			qval_q[wr_ptr_q] <= DATA_WIDTH'(items.load_value);
		end
	end

	assign cmd_valid = cnt_q != '0;
	assign cmd       = qcmd_q[rd_ptr_q];
	assign cmd_value = qval_q[rd_ptr_q];

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("Command queue holds more items than its depth.");
	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		wr_ptr_q == QPTR_W'(rd_ptr_q + QPTR_W'(cnt_q)))
		else $error("Queue pointers disagree with the fill count.");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cnt_q != '0)
		else $error("Command popped from an empty queue.");
`endif

endmodule

`default_nettype wire

// ===== rtl/dlmv_back.sv =====
// Back end: writes loads into the stores and runs the multiply-accumulate sequence
// for a start, one row at a time, into a result register. Depends on dlmv_pkg,
// dlmv_if and dlmv_ram.
`timescale 1ns / 1ps
`default_nettype none

module dlmv_back import dlmv_pkg::*; #(
	parameter int MAX_INPUTS  = 256,
	parameter int MAX_OUTPUTS = 64,
	parameter int DATA_WIDTH  = 16,
	parameter int ACC_WIDTH   = 40
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  logic                  cmd_valid,
	input  cmd_t                  cmd,
	input  logic [DATA_WIDTH-1:0] cmd_value,
	output logic                  cmd_pop,
	dlmv_result_if.source         results
);

	localparam int IN_AW   = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
	localparam int OUT_AW  = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
	localparam int W_DEPTH = MAX_INPUTS * MAX_OUTPUTS;
	localparam int W_AW    = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
	localparam int KC_W    = $clog2(MAX_INPUTS + 1);
	localparam int MC_W    = $clog2(MAX_OUTPUTS + 1);
	localparam int PROD_W  = 2 * DATA_WIDTH;
	localparam int PX_W    = (PROD_W > ACC_WIDTH) ? PROD_W : ACC_WIDTH;
	localparam int BSH_W   = DATA_WIDTH + FRAC_BITS;
	localparam int BX_W    = (BSH_W > ACC_WIDTH) ? BSH_W : ACC_WIDTH;

	typedef enum logic [2:0] {
		S_IDLE,
		S_BIAS,
		S_MAC,
		S_DRAIN,
		S_EMIT
	} state_t;

	state_t                   state_q;
	logic [KC_W-1:0]          k_q;
	logic [KC_W-1:0]          n_in_q;
	logic [MC_W-1:0]          row_q;
	logic [MC_W-1:0]          n_out_q;
	logic [W_AW-1:0]          base_q;
	logic [ACC_WIDTH-1:0]     acc_q;
	logic                     mac_vld_s1;
	logic                     mac_vld_s2;
	logic                     bias_vld_s1;
	logic signed [PX_W-1:0]   prod_s2;
	logic                     res_valid_q;
	logic [ROW_W-1:0]         res_row_q;
	logic [RES_W-1:0]         res_value_q;
	logic                     res_last_q;

	logic [KC_W-1:0]          n_in_cfg;
	logic [MC_W-1:0]          n_out_cfg;
	logic                     issue;
	logic                     in_we;
	logic                     w_we;
	logic                     b_we;
	logic [IN_AW-1:0]         in_waddr;
	logic [W_AW-1:0]          w_waddr;
	logic [OUT_AW-1:0]        b_waddr;
	logic [IN_AW-1:0]         in_raddr;
	logic [W_AW-1:0]          w_raddr;
	logic [OUT_AW-1:0]        b_raddr;
	logic signed [DATA_WIDTH-1:0] in_rd;
	logic signed [DATA_WIDTH-1:0] w_rd;
	logic signed [DATA_WIDTH-1:0] b_rd;
	logic signed [PROD_W-1:0] prod;
	logic signed [BSH_W-1:0]  bias_sh;
	logic signed [BX_W-1:0]   bias_x;
	logic [ACC_WIDTH-32:0]    acc_hi;
	logic [RES_W-1:0]         sat_value;
	logic                     emit_go;
	logic                     row_last;

	assign n_in_cfg  = (32'(cfg.input_length) > 32'(MAX_INPUTS)) ?
		KC_W'(MAX_INPUTS) : KC_W'(cfg.input_length);
	assign n_out_cfg = (32'(cfg.output_length) > 32'(MAX_OUTPUTS)) ?
		MC_W'(MAX_OUTPUTS) : MC_W'(cfg.output_length);

	assign cmd_pop  = (state_q == S_IDLE) && cmd_valid;
	assign in_we    = cmd_pop && (cmd.op == OP_LOAD_INPUT);
	assign w_we     = cmd_pop && (cmd.op == OP_LOAD_WEIGHT);
	assign b_we     = cmd_pop && (cmd.op == OP_LOAD_BIAS);
	assign in_waddr = IN_AW'(cmd.col);
	assign w_waddr  = W_AW'(32'(cmd.row) * MAX_INPUTS + 32'(cmd.col));
	assign b_waddr  = OUT_AW'(cmd.row);

	assign issue    = (state_q == S_MAC) && (k_q != n_in_q);
	assign in_raddr = k_q[IN_AW-1:0];
	assign w_raddr  = W_AW'(base_q + W_AW'(k_q));
	assign b_raddr  = row_q[OUT_AW-1:0];

	dlmv_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_INPUTS)) u_in_ram (
		.clk     (clk),
		.wr_en   (in_we),
		.wr_addr (in_waddr),
		.wr_data (cmd_value),
		.rd_en   (issue),
		.rd_addr (in_raddr),
		.rd_data (in_rd)
	);

	dlmv_ram #(.WIDTH(DATA_WIDTH), .DEPTH(W_DEPTH)) u_w_ram (
		.clk     (clk),
		.wr_en   (w_we),
		.wr_addr (w_waddr),
		.wr_data (cmd_value),
		.rd_en   (issue),
		.rd_addr (w_raddr),
		.rd_data (w_rd)
	);

	dlmv_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_OUTPUTS)) u_b_ram (
		.clk     (clk),
		.wr_en   (b_we),
		.wr_addr (b_waddr),
		.wr_data (cmd_value),
		.rd_en   (state_q == S_BIAS),
		.rd_addr (b_raddr),
		.rd_data (b_rd)
	);

	assign prod    = PROD_W'(in_rd) * PROD_W'(w_rd);
	assign bias_sh = signed'({b_rd, {FRAC_BITS{1'b0}}});
	assign bias_x  = BX_W'(bias_sh);

	// The sum fits in 32 bits when every bit above bit 30 equals the sign.
	assign acc_hi = acc_q[ACC_WIDTH-1:31];
	always_comb begin
		if ((&acc_hi) || !(|acc_hi)) begin
			sat_value = acc_q[RES_W-1:0];
		end else if (acc_q[ACC_WIDTH-1]) begin
			sat_value = {1'b1, {(RES_W-1){1'b0}}};
		end else begin
			sat_value = {1'b0, {(RES_W-1){1'b1}}};
		end
	end

	assign emit_go  = (state_q == S_EMIT) && (!res_valid_q || results.ready);
	assign row_last = MC_W'(row_q + MC_W'(1)) == n_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			k_q         <= '0;
			n_in_q      <= '0;
			row_q       <= '0;
			n_out_q     <= '0;
			base_q      <= '0;
			acc_q       <= '0;
			mac_vld_s1  <= 1'b0;
			mac_vld_s2  <= 1'b0;
			bias_vld_s1 <= 1'b0;
			res_valid_q <= 1'b0;
			res_last_q  <= 1'b0;
		end else begin
			mac_vld_s1  <= issue;
			mac_vld_s2  <= mac_vld_s1;
			bias_vld_s1 <= state_q == S_BIAS;

			if (bias_vld_s1) begin
				acc_q <= cfg.bias_enable ? bias_x[ACC_WIDTH-1:0] : '0;
			end else if (mac_vld_s2) begin
				acc_q <= acc_q + prod_s2[ACC_WIDTH-1:0];
			end

			if (emit_go) begin
				res_valid_q <= 1'b1;
			end else if (results.ready) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (cmd_valid && (cmd.op == OP_START)) begin
						n_in_q  <= n_in_cfg;
						n_out_q <= n_out_cfg;
						row_q   <= '0;
						base_q  <= '0;
						if (n_out_cfg != '0) begin
							state_q <= S_BIAS;
						end
					end
				end
				S_BIAS: begin
					k_q     <= '0;
					state_q <= S_MAC;
				end
				S_MAC: begin
					if (issue) begin
						k_q <= KC_W'(k_q + KC_W'(1));
					end else begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (!mac_vld_s1 && !mac_vld_s2 && !bias_vld_s1) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit_go) begin
						res_last_q <= row_last;
						if (row_last) begin
							state_q <= S_IDLE;
						end else begin
							row_q   <= MC_W'(row_q + MC_W'(1));
							base_q  <= W_AW'(base_q + W_AW'(MAX_INPUTS));
							state_q <= S_BIAS;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mac_vld_s1) begin
			prod_s2 <= PX_W'(prod);
		end
		if (emit_go) begin
			res_row_q   <= ROW_W'(row_q);
			res_value_q <= sat_value;
		end
	end

	assign results.valid        = res_valid_q;
	assign results.result_row   = res_row_q;
	assign results.result_value = signed'(res_value_q);
	assign results.last_row     = res_last_q;

`ifndef SYNTHESIS
	a_acc_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		!(mac_vld_s2 && bias_vld_s1))
		else $error("Bias load and product accumulate collide.");
	a_emit_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT |-> !mac_vld_s1 && !mac_vld_s2 && !bias_vld_s1)
		else $error("Row result taken while products are still in flight.");
	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> row_q < n_out_q)
		else $error("Row counter ran past the output length.");
	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MAC |-> k_q <= n_in_q)
		else $error("Column counter ran past the input length.");
`endif

endmodule

`default_nettype wire
